>>> sv/sssq_pkg.sv
// Shared types and constants for the sparse scaled sum-of-squares block.
// Used by the controller, the datapath, the top level and the checker; no dependencies.
`default_nettype none

package sssq_pkg;

    typedef struct packed {
        logic               entry_present;
        logic               from_second;
        logic [9:0]         column;
        logic signed [31:0] entry_value;
        logic               end_of_row;
        logic               end_of_matrix;
    } entry_t;

    typedef struct packed {
        logic [63:0] sum_of_squares;
        logic        saturated;
    } result_t;

    typedef enum logic [1:0] {
        CFG_ALPHA     = 2'd0,
        CFG_BETA      = 2'd1,
        CFG_THRESHOLD = 2'd2
    } cfg_reg_t;

    localparam logic signed [31:0] SCALE_ONE = 32'sd65536;
    localparam logic signed [31:0] ACC_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] ACC_MIN   = 32'sh8000_0000;

    typedef struct packed {
        logic clear;
        logic load;
        logic update;
        logic list_rd;
        logic col_rd;
        logic square;
        logic walk_finish;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic hit;
        logic close;
        logic item_close;
        logic item_end;
        logic walk_done;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

>>> sv/sparse_scaled_sum_squares_core.sv
// Sparse scaled sum of squares: entries of two matrices stream in row by row, are scaled by
// alpha or beta (Q16.16), accumulated per column, and at each row end every touched column
// whose magnitude exceeds the threshold adds its square to a saturating Q32.32 sum, emitted on
// the end-of-matrix item. After reset the block sweeps every column memory entry with
// entry_stall high; configuration writes are taken during that sweep. An item carrying an
// in-range entry is read from memory and multiplied, then updated; a bare marker needs only
// the load step. Closing a row walks each touched column through list read, column read and
// square, then finishes the walk, and a matrix end adds an emit step, which waits only while
// a previous result still waits. One item is processed at a time.
`default_nettype none

module sparse_scaled_sum_squares_core #(
    parameter int MAX_COLUMNS         = 1024,
    parameter int MAX_ENTRIES_PER_ROW = 64
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_write,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [31:0]      cfg_data,
    input  wire logic             entry_valid,
    output logic                  entry_stall,
    input  wire sssq_pkg::entry_t entry,
    output logic                  result_valid,
    input  wire logic             result_stall,
    output sssq_pkg::result_t     result
);

    sssq_pkg::cmd_t    cmd;
    sssq_pkg::status_t status;

    sssq_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .entry_valid (entry_valid),
        .entry_stall (entry_stall),
        .status      (status),
        .cmd         (cmd)
    );

    sssq_datapath #(
        .MAX_COLUMNS         (MAX_COLUMNS),
        .MAX_ENTRIES_PER_ROW (MAX_ENTRIES_PER_ROW)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .entry        (entry),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result       (result),
        .cmd          (cmd),
        .status       (status)
    );

endmodule

`default_nettype wire

>>> sv/sssq_ctrl.sv
// Controller state machine: sequences clearing, column update, row walk and result emit.
// Depends on sssq_pkg for the command and status structs.
`default_nettype none

module sssq_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             entry_valid,
    output logic                  entry_stall,
    input  wire sssq_pkg::status_t status,
    output sssq_pkg::cmd_t        cmd
);

    typedef enum logic [6:0] {
        ST_CLEAR     = 7'b000_0001,
        ST_IDLE      = 7'b000_0010,
        ST_UPDATE    = 7'b000_0100,
        ST_WALK_LIST = 7'b000_1000,
        ST_WALK_COL  = 7'b001_0000,
        ST_WALK_SQ   = 7'b010_0000,
        ST_EMIT      = 7'b100_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign entry_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (entry_valid)
                begin
                    cmd.load = 1'b1;
                    priority if (status.hit)
                    begin
                        state_next = ST_UPDATE;
                    end
                    else if (status.close)
                    begin
                        state_next = ST_WALK_LIST;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = status.item_close ? ST_WALK_LIST : ST_IDLE;
            end
            ST_WALK_LIST:
            begin
                if (status.walk_done)
                begin
                    cmd.walk_finish = 1'b1;
                    state_next      = status.item_end ? ST_EMIT : ST_IDLE;
                end
                else
                begin
                    cmd.list_rd = 1'b1;
                    state_next  = ST_WALK_COL;
                end
            end
            ST_WALK_COL:
            begin
                cmd.col_rd = 1'b1;
                state_next = ST_WALK_SQ;
            end
            ST_WALK_SQ:
            begin
                cmd.square = 1'b1;
                state_next = ST_WALK_LIST;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/sssq_datapath.sv
// Datapath: configuration registers, column and touched-list memories, scaling multiplier,
// saturating accumulate, squaring and the running sum with its output register.
// Depends on sssq_pkg; driven by sssq_ctrl through cmd_t and answers with status_t.
`default_nettype none

module sssq_datapath #(
    parameter int MAX_COLUMNS         = 1024,
    parameter int MAX_ENTRIES_PER_ROW = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_write,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [31:0]       cfg_data,
    input  wire sssq_pkg::entry_t  entry,
    input  wire logic              result_stall,
    output logic                   result_valid,
    output sssq_pkg::result_t      result,
    input  wire sssq_pkg::cmd_t    cmd,
    output sssq_pkg::status_t      status
);

    localparam int COL_AW     = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int LIST_DEPTH = 2 * MAX_ENTRIES_PER_ROW;
    localparam int LIST_AW    = $clog2(LIST_DEPTH);
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

    logic signed [31:0] alpha_reg;
    logic signed [31:0] beta_reg;
    logic [30:0]        thresh_reg;

    logic [32:0]        col_mem [MAX_COLUMNS];
    logic [COL_AW-1:0]  list_mem [LIST_DEPTH];
    logic [32:0]        col_rd_reg;
    logic [COL_AW-1:0]  list_rd_reg;

    logic [COL_AW-1:0]  clr_idx_reg;
    logic [COL_AW-1:0]  item_col_reg;
    logic               item_close_reg;
    logic               item_end_reg;
    logic signed [63:0] prod_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   walk_idx_reg;
    logic [63:0]        sq_reg;
    logic               sq_pend_reg;
    logic [63:0]        run_sum_reg;
    logic               sat_reg;
    logic               result_valid_reg;
    sssq_pkg::result_t  result_reg;

    logic               in_col_ok;
    logic signed [31:0] scale_sel;
    logic signed [31:0] value_s;
    logic signed [63:0] prod_next;

    logic               touched;
    logic               list_full;
    logic               upd_keep;
    logic               upd_new;
    logic signed [31:0] acc_base;
    logic signed [48:0] sum_wide;
    logic               upd_hi;
    logic               upd_lo;
    logic signed [31:0] upd_val;

    logic signed [31:0] sq_acc;
    logic [31:0]        mag;
    logic               keep;
    logic [63:0]        sq_next;
    logic [64:0]        run_wide;

    logic               col_we;
    logic [COL_AW-1:0]  col_waddr;
    logic [32:0]        col_wdata;
    logic               col_re;
    logic [COL_AW-1:0]  col_raddr;
    logic               list_we;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg  <= sssq_pkg::SCALE_ONE;
            beta_reg   <= sssq_pkg::SCALE_ONE;
            thresh_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                sssq_pkg::CFG_ALPHA:     alpha_reg  <= cfg_data;
                sssq_pkg::CFG_BETA:      beta_reg   <= cfg_data;
                sssq_pkg::CFG_THRESHOLD: thresh_reg <= cfg_data[30:0];
                default:
                begin
                end
            endcase
        end
    end

    // scale the incoming entry
    always_comb
    begin
        in_col_ok = (32'(entry.column) < 32'(MAX_COLUMNS));
        scale_sel = entry.from_second ? beta_reg : alpha_reg;
        value_s   = entry.entry_value;
        prod_next = value_s * scale_sel;
    end

    // column update: floor shift, exact add, clamp
    always_comb
    begin
        touched   = col_rd_reg[32];
        list_full = (count_reg == CNT_W'(LIST_DEPTH));
        upd_keep  = touched || !list_full;
        upd_new   = !touched && !list_full;
        acc_base  = touched ? $signed(col_rd_reg[31:0]) : 32'sd0;
        sum_wide  = 49'(acc_base) + 49'(prod_reg >>> 16);
        upd_hi    = (sum_wide > 49'(sssq_pkg::ACC_MAX));
        upd_lo    = (sum_wide < 49'(sssq_pkg::ACC_MIN));
        priority if (upd_hi)
        begin
            upd_val = sssq_pkg::ACC_MAX;
        end
        else if (upd_lo)
        begin
            upd_val = sssq_pkg::ACC_MIN;
        end
        else
        begin
            upd_val = sum_wide[31:0];
        end
    end

    // row walk: magnitude, threshold, square, saturating add
    always_comb
    begin
        sq_acc   = col_rd_reg[31:0];
        mag      = sq_acc[31] ? 32'(-sq_acc) : sq_acc;
        keep     = (mag > {1'b0, thresh_reg});
        sq_next  = keep ? (64'(mag) * 64'(mag)) : 64'd0;
        run_wide = {1'b0, run_sum_reg} + {1'b0, sq_reg};
    end

    // memory port selection
    always_comb
    begin
        col_we    = cmd.clear || (cmd.update && upd_keep) || cmd.square;
        col_waddr = clr_idx_reg;
        col_wdata = '0;
        priority if (cmd.update)
        begin
            col_waddr = item_col_reg;
            col_wdata = {1'b1, upd_val};
        end
        else if (cmd.square)
        begin
            col_waddr = list_rd_reg;
        end
        else
        begin
            col_waddr = clr_idx_reg;
        end
        col_re    = (cmd.load && entry.entry_present && in_col_ok) || cmd.col_rd;
        col_raddr = cmd.col_rd ? list_rd_reg : COL_AW'(entry.column);
        list_we   = cmd.update && upd_new;
    end

    always_ff @(posedge clk)
    begin
        if (col_we)
        begin
            col_mem[col_waddr] <= col_wdata;
        end
        if (col_re)
        begin
            col_rd_reg <= col_mem[col_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (list_we)
        begin
            list_mem[count_reg[LIST_AW-1:0]] <= item_col_reg;
        end
        if (cmd.list_rd)
        begin
            list_rd_reg <= list_mem[walk_idx_reg[LIST_AW-1:0]];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_col_reg <= COL_AW'(entry.column);
            prod_reg     <= prod_next;
        end
        if (cmd.square)
        begin
            sq_reg <= sq_next;
        end
        if (cmd.emit)
        begin
            result_reg.sum_of_squares <= run_sum_reg;
            result_reg.saturated      <= sat_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg      <= '0;
            item_close_reg   <= 1'b0;
            item_end_reg     <= 1'b0;
            count_reg        <= '0;
            walk_idx_reg     <= '0;
            sq_pend_reg      <= 1'b0;
            run_sum_reg      <= '0;
            sat_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end
            if (cmd.load)
            begin
                item_close_reg <= entry.end_of_row || entry.end_of_matrix;
                item_end_reg   <= entry.end_of_matrix;
            end
            priority if (cmd.walk_finish)
            begin
                count_reg    <= '0;
                walk_idx_reg <= '0;
            end
            else
            begin
                if (list_we)
                begin
                    count_reg <= count_reg + 1'b1;
                end
                if (cmd.list_rd)
                begin
                    walk_idx_reg <= walk_idx_reg + 1'b1;
                end
            end
            sq_pend_reg <= cmd.square;
            priority if (cmd.emit)
            begin
                run_sum_reg <= '0;
                sat_reg     <= 1'b0;
            end
            else
            begin
                if (sq_pend_reg)
                begin
                    run_sum_reg <= run_wide[64] ? '1 : run_wide[63:0];
                end
                if ((sq_pend_reg && run_wide[64])
                    || (cmd.update && upd_keep && (upd_hi || upd_lo)))
                begin
                    sat_reg <= 1'b1;
                end
            end
            priority if (cmd.emit)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        status.clear_last = (clr_idx_reg == COL_AW'(MAX_COLUMNS - 1));
        status.hit        = entry.entry_present && in_col_ok;
        status.close      = entry.end_of_row || entry.end_of_matrix;
        status.item_close = item_close_reg;
        status.item_end   = item_end_reg;
        status.walk_done  = (walk_idx_reg == count_reg);
        status.out_free   = !result_valid_reg || !result_stall;
    end

endmodule

`default_nettype wire

>>> sv/sssq_checker.sv
// Port-level checker for sparse_scaled_sum_squares_core, bound to the top level below.
// Depends on sssq_pkg for the item structs.
`default_nettype none

module sssq_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              entry_valid,
    input wire logic              entry_stall,
    input wire sssq_pkg::entry_t  entry,
    input wire logic              result_valid,
    input wire logic              result_stall,
    input wire sssq_pkg::result_t result
);

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result dropped while stalled");

    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(result))
        else $error("result changed while stalled");

    a_entry_busy: assert property (@(posedge clk) disable iff (!rst_n)
        entry_valid && !entry_stall && entry.entry_present |=> entry_stall)
        else $error("entry item did not hold off the next item");

    a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(entry_stall))
        else $error("result appeared without a busy emit cycle");

endmodule

bind sparse_scaled_sum_squares_core sssq_checker u_checker (.*);

`default_nettype wire

>>> sim/sparse_scaled_sum_squares_core_tb.sv
`timescale 1ns / 100ps
// Testbench for sparse_scaled_sum_squares_core: streams rows of tagged sparse entries under
// several scale and threshold settings and checks each emitted sum of squares field by field.
// Depends on sssq_pkg and the core RTL.

module sparse_scaled_sum_squares_core_tb;

    localparam int NUM_COLUMNS   = 1024;
    localparam int LIST_DEPTH    = 128;
    localparam int LIST_AW       = $clog2(LIST_DEPTH);
    localparam int SETTLE_CYCLES = 400;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              cfg_write    = 1'b0;
    logic [1:0]        cfg_index    = sssq_pkg::CFG_ALPHA;
    logic [31:0]       cfg_data     = '0;
    logic              entry_valid  = 1'b0;
    logic              entry_stall;
    sssq_pkg::entry_t  entry        = '0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    sssq_pkg::result_t result;

    sssq_pkg::entry_t  pending_items[$];
    sssq_pkg::result_t expected_sums[$];

    logic signed [31:0] alpha_copy     = sssq_pkg::SCALE_ONE;
    logic signed [31:0] beta_copy      = sssq_pkg::SCALE_ONE;
    logic [30:0]        threshold_copy = '0;
    logic signed [31:0] col_sum[NUM_COLUMNS];
    bit                 col_hit[NUM_COLUMNS];
    logic [9:0]         hit_list[LIST_DEPTH];
    int                 hit_count;
    logic [63:0]        square_total;
    bit                 clamp_seen;

    int send_idle_pct;
    int recv_idle_pct;
    int phase_items;
    int items_sent;
    int sums_checked;
    int saturated_sums;
    int errors;

    sparse_scaled_sum_squares_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .entry_valid  (entry_valid),
        .entry_stall  (entry_stall),
        .entry        (entry),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void scatter_entry(input logic [9:0] col, input logic second,
                                          input logic signed [31:0] value);
        longint product;
        longint total;
        if (!col_hit[col])
        begin
            if (hit_count >= LIST_DEPTH)
                return;
            col_hit[col]                    = 1'b1;
            col_sum[col]                    = '0;
            hit_list[LIST_AW'(hit_count)]   = col;
            hit_count++;
        end
        product = longint'(value) * longint'(second ? beta_copy : alpha_copy);
        total   = longint'(col_sum[col]) + (product >>> 16);
        if (total > longint'(sssq_pkg::ACC_MAX))
        begin
            total      = longint'(sssq_pkg::ACC_MAX);
            clamp_seen = 1'b1;
        end
        else if (total < longint'(sssq_pkg::ACC_MIN))
        begin
            total      = longint'(sssq_pkg::ACC_MIN);
            clamp_seen = 1'b1;
        end
        col_sum[col] = total[31:0];
    endfunction

    function automatic void fold_row_squares();
        logic [9:0]  col;
        longint      mag;
        logic [63:0] square;
        for (int i = 0; i < hit_count; i++)
        begin
            col = hit_list[LIST_AW'(i)];
            mag = longint'(col_sum[col]);
            if (mag < 0)
                mag = -mag;
            if (64'(mag) > {33'b0, threshold_copy})
            begin
                square = 64'(mag) * 64'(mag);
                if (square_total > ~64'd0 - square)
                begin
                    square_total = ~64'd0;
                    clamp_seen   = 1'b1;
                end
                else
                begin
                    square_total = square_total + square;
                end
            end
            col_sum[col] = '0;
            col_hit[col] = 1'b0;
        end
        hit_count = 0;
    endfunction

    function automatic void predict_sum_of_squares(input sssq_pkg::entry_t it);
        sssq_pkg::result_t sum;
        if (it.entry_present)
            scatter_entry(it.column, it.from_second, it.entry_value);
        if (it.end_of_row || it.end_of_matrix)
            fold_row_squares();
        if (it.end_of_matrix)
        begin
            sum.sum_of_squares = square_total;
            sum.saturated      = clamp_seen;
            expected_sums.push_back(sum);
            square_total = '0;
            clamp_seen   = 1'b0;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (entry_valid && !entry_stall)
            begin
                predict_sum_of_squares(entry);
                items_sent++;
            end
            if (!entry_valid || !entry_stall)
            begin
                if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    entry       <= pending_items.pop_front();
                    entry_valid <= 1'b1;
                end
                else
                begin
                    entry_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        sssq_pkg::result_t want;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_sums.size() == 0)
                begin
                    $error("unexpected result: sum_of_squares %h saturated %b",
                           result.sum_of_squares, result.saturated);
                    errors++;
                end
                else
                begin
                    want = expected_sums.pop_front();
                    if (result.sum_of_squares !== want.sum_of_squares)
                    begin
                        $error("sum_of_squares: expected %h, got %h",
                               want.sum_of_squares, result.sum_of_squares);
                        errors++;
                    end
                    if (result.saturated !== want.saturated)
                    begin
                        $error("saturated: expected %b, got %b", want.saturated,
                               result.saturated);
                        errors++;
                    end
                    sums_checked++;
                    if (want.saturated)
                        saturated_sums++;
                end
            end
            result_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    function automatic void add_item(input logic present, input logic second,
                                     input logic [9:0] col, input logic signed [31:0] value,
                                     input logic row_end, input logic matrix_end);
        sssq_pkg::entry_t it;
        it.entry_present = present;
        it.from_second   = second;
        it.column        = col;
        it.entry_value   = value;
        it.end_of_row    = row_end;
        it.end_of_matrix = matrix_end;
        pending_items.push_back(it);
        if (present || row_end || matrix_end)
            phase_items++;
    endfunction

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(9))
            0:       return sssq_pkg::ACC_MAX;
            1:       return sssq_pkg::ACC_MIN;
            2:       return '0;
            3, 4, 5: return $signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
            default: return $urandom;
        endcase
    endfunction

    function automatic void build_matrix();
        int         rows;
        int         count;
        bit         last_row;
        bit         mark_on_entry;
        logic [9:0] base;
        logic [9:0] col;
        rows = $urandom_range(1, 4);
        for (int r = 0; r < rows; r++)
        begin
            count         = $urandom_range(0, 6);
            base          = 10'($urandom);
            last_row      = (r == rows - 1);
            mark_on_entry = (count > 0) && ($urandom_range(3) != 0);
            for (int k = 0; k < count; k++)
            begin
                col = $urandom_range(1) ? base + 10'($urandom_range(3)) : 10'($urandom);
                add_item(1'b1, 1'($urandom_range(1)), col, pick_value(),
                         mark_on_entry && k == count - 1 && (!last_row || $urandom_range(1)),
                         mark_on_entry && k == count - 1 && last_row);
            end
            if (!mark_on_entry)
                add_item(1'b0, 1'($urandom_range(1)), 10'($urandom), $urandom,
                         !last_row || $urandom_range(1), last_row);
        end
    endfunction

    // overflow the touched list, revisit a listed column, then close the matrix
    function automatic void build_wide_row();
        logic [9:0] base;
        base = 10'($urandom);
        for (int i = 0; i < LIST_DEPTH + 12; i++)
            add_item(1'b1, 1'($urandom_range(1)), base + 10'(i * 7), pick_value(),
                     1'b0, 1'b0);
        add_item(1'b1, 1'($urandom_range(1)), base, pick_value(), 1'b0, 1'b0);
        add_item(1'b0, 1'b0, '0, '0, 1'b0, 1'b1);
    endfunction

    task automatic run_random(input int count);
        while (phase_items < count)
        begin
            if ($urandom_range(99) < 85)
                build_matrix();
            else
                add_item(1'($urandom_range(1)), 1'($urandom_range(1)), 10'($urandom),
                         $urandom, $urandom_range(3) == 0, $urandom_range(9) == 0);
        end
        add_item(1'b0, 1'($urandom_range(1)), 10'($urandom), $urandom,
                 1'($urandom_range(1)), 1'b1);
    endtask

    task automatic drain();
        @(negedge clk);
        while (pending_items.size() != 0 || entry_valid || expected_sums.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        phase_items = 0;
    endtask

    task automatic load_settings(input logic signed [31:0] alpha,
                                 input logic signed [31:0] beta, input logic [30:0] threshold);
        alpha_copy     = alpha;
        beta_copy      = beta;
        threshold_copy = threshold;
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= sssq_pkg::CFG_ALPHA;
        cfg_data  <= alpha;
        @(posedge clk);
        cfg_index <= sssq_pkg::CFG_BETA;
        cfg_data  <= beta;
        @(posedge clk);
        cfg_index <= sssq_pkg::CFG_THRESHOLD;
        cfg_data  <= {1'b0, threshold};
        @(posedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        for (int i = 0; i < NUM_COLUMNS; i++)
        begin
            col_sum[10'(i)] = '0;
            col_hit[10'(i)] = 1'b0;
        end
        hit_count     = 0;
        square_total  = '0;
        clamp_seen    = 1'b0;
        phase_items   = 0;
        send_idle_pct = 38;
        recv_idle_pct = 54;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        add_item(1'b1, 1'b0, 10'd0, 32'sd65536, 1'b0, 1'b0);
        add_item(1'b1, 1'b1, 10'd0, -32'sd131072, 1'b1, 1'b0);
        add_item(1'b0, 1'b1, 10'h3FF, 32'h1234_5678, 1'b0, 1'b1);
        add_item(1'b1, 1'b0, 10'h3FF, sssq_pkg::ACC_MAX, 1'b0, 1'b1);
        add_item(1'b1, 1'b0, 10'd5, sssq_pkg::ACC_MIN, 1'b0, 1'b0);
        add_item(1'b1, 1'b1, 10'd5, sssq_pkg::ACC_MIN, 1'b1, 1'b1);
        for (int i = 10; i < 15; i++)
            add_item(1'b1, i[0], 10'(i), sssq_pkg::ACC_MAX, 1'b0, i == 14);
        add_item(1'b1, 1'b0, 10'd20, sssq_pkg::ACC_MAX, 1'b0, 1'b0);
        add_item(1'b1, 1'b1, 10'd20, sssq_pkg::ACC_MAX, 1'b0, 1'b0);
        add_item(1'b1, 1'b0, 10'd20, sssq_pkg::ACC_MIN, 1'b0, 1'b1);
        add_item(1'b1, 1'b0, 10'd7, '0, 1'b1, 1'b0);
        add_item(1'b0, 1'b0, '0, '0, 1'b1, 1'b0);
        add_item(1'b1, 1'b1, 10'd3, -32'sd1, 1'b0, 1'b0);
        add_item(1'b1, 1'b0, 10'd3, 32'sd1, 1'b0, 1'b0);
        add_item(1'b1, 1'b0, 10'd900, 32'sd65536, 1'b1, 1'b0);
        add_item(1'b0, 1'b0, '0, '0, 1'b0, 1'b1);
        drain();

        load_settings(32'sh0001_8000, -32'sd65536, 31'd65536);
        add_item(1'b1, 1'b1, 10'd1, 32'sd65536, 1'b1, 1'b0);
        add_item(1'b1, 1'b1, 10'd2, 32'sd65537, 1'b1, 1'b0);
        add_item(1'b1, 1'b0, 10'd3, 32'sd43691, 1'b0, 1'b1);
        run_random(60);
        drain();

        load_settings(sssq_pkg::ACC_MAX, sssq_pkg::ACC_MIN, 31'h7FFF_FFFF);
        run_random(60);
        drain();

        send_idle_pct = 54;
        recv_idle_pct = 38;
        load_settings('0, $urandom, '0);
        run_random(60);
        drain();

        load_settings($urandom, $urandom, 31'($urandom_range(0, 1 << 20)));
        build_wide_row();
        run_random(120);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        load_settings(sssq_pkg::ACC_MIN, sssq_pkg::ACC_MAX, '0);
        run_random(60);
        drain();

        load_settings(32'sd1, -32'sd1, 31'($urandom));
        build_wide_row();
        run_random(120);
        drain();

        $display("%0d items over 7 scale/threshold settings, %0d sums checked (%0d saturated)",
                 items_sent, sums_checked, saturated_sums);
        if (errors == 0)
            $display("[sparse_scaled_sum_squares_core] OK");
        else
            $display("[sparse_scaled_sum_squares_core] ERROR");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("[sparse_scaled_sum_squares_core] ERROR");
        $finish;
    end

endmodule

>>> filelist.f
sv/sssq_pkg.sv
sv/sssq_ctrl.sv
sv/sssq_datapath.sv
sv/sparse_scaled_sum_squares_core.sv
sv/sssq_checker.sv
sim/sparse_scaled_sum_squares_core_tb.sv
